### design/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, constants and the init step table for the 4-bit LCD
// write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned HOLD_W   = 15;
  localparam int unsigned STEP_W   = 5;

  // Request codes on the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_CURSOR = 3'd4,
    ACT_CUR_ON = 3'd5,
    ACT_BLINK  = 3'd6,
    ACT_NONE   = 3'd7
  } action_e;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_CUR_ON   = 8'h0E;
  localparam logic [7:0] CMD_BLINK    = 8'h0F;

  localparam logic [HOLD_W-1:0] HOLD_EN_HIGH = 15'd3;
  localparam logic [HOLD_W-1:0] HOLD_EN_LOW  = 15'd50;
  localparam logic [HOLD_W-1:0] HOLD_LONG    = 15'd2050;
  localparam logic [HOLD_W-1:0] HOLD_PWR_UP  = 15'd20000;
  localparam logic [HOLD_W-1:0] HOLD_WAKE_1  = 15'd5050;
  localparam logic [HOLD_W-1:0] HOLD_WAKE_2  = 15'd150;

  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd24;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic       is_init;
    logic       sel;
    logic       long_tail;
    logic [7:0] data;
  } job_t;

  // One pin-state step on the LCD bus.
  typedef struct packed {
    logic [3:0]        nibble;
    logic              en;
    logic              sel;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } step_t;

  // Power-up wake-up run: 8-bit mode nibbles, 4-bit switch, then function set,
  // display on, entry mode and clear.
  function automatic step_t init_step(logic [STEP_W-1:0] idx);
    step_t s;
    s = '{nibble: 4'h0, en: 1'b0, sel: 1'b0, hold: HOLD_EN_LOW, last: 1'b0};
    unique case (idx)
      5'd0:  s.hold = HOLD_PWR_UP;
      5'd1, 5'd3, 5'd5: begin
        s.nibble = 4'h3; s.en = 1'b1; s.hold = HOLD_EN_HIGH;
      end
      5'd2:  begin s.nibble = 4'h3; s.hold = HOLD_WAKE_1; end
      5'd4:  begin s.nibble = 4'h3; s.hold = HOLD_WAKE_2; end
      5'd6:  s.nibble = 4'h3;
      5'd7, 5'd9: begin s.nibble = 4'h2; s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd8, 5'd10: s.nibble = 4'h2;
      5'd11: begin s.nibble = 4'h8; s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd12: s.nibble = 4'h8;
      5'd13, 5'd17, 5'd21: begin s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd14, 5'd18, 5'd22: s.nibble = 4'h0;
      5'd15: begin s.nibble = 4'hC; s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd16: s.nibble = 4'hC;
      5'd19: begin s.nibble = 4'h6; s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd20: s.nibble = 4'h6;
      5'd23: begin s.nibble = 4'h1; s.en = 1'b1; s.hold = HOLD_EN_HIGH; end
      5'd24: begin s.nibble = 4'h1; s.hold = HOLD_LONG; s.last = 1'b1; end
      default: s.last = 1'b1;
    endcase
    return s;
  endfunction

endpackage

### design/lcdseq_front.sv
// ----------------------------------------------------------------------------
// lcdseq_front
// Decodes a request beat into a job for the step generator. Unused action
// codes are swallowed here and produce no job.
// ----------------------------------------------------------------------------
module lcdseq_front (
  input  logic [23:0]         req_data_i,
  output lcdseq_pkg::job_t    job_o,
  output logic                job_valid_o
);

  lcdseq_pkg::action_e action;
  logic [7:0]          value;
  logic [5:0]          column;
  logic                row;

  assign action = lcdseq_pkg::action_e'(req_data_i[2:0]);
  assign value  = req_data_i[10:3];
  assign column = req_data_i[16:11];
  assign row    = req_data_i[17];

  always_comb begin
    job_o       = '{is_init: 1'b0, sel: 1'b0, long_tail: 1'b0, data: value};
    job_valid_o = 1'b1;
    unique case (action)
      lcdseq_pkg::ACT_INIT:   job_o.is_init = 1'b1;
      lcdseq_pkg::ACT_CMD:    job_o.data = value;
      lcdseq_pkg::ACT_DATA:   job_o.sel = 1'b1;
      lcdseq_pkg::ACT_CLEAR: begin
        job_o.data      = lcdseq_pkg::CMD_CLEAR;
        job_o.long_tail = 1'b1;
      end
      // DDRAM address: 0x80 + column on the top row, 0xC0 + column below.
      lcdseq_pkg::ACT_CURSOR: job_o.data = {1'b1, row, column};
      lcdseq_pkg::ACT_CUR_ON: job_o.data = lcdseq_pkg::CMD_CUR_ON;
      lcdseq_pkg::ACT_BLINK:  job_o.data = lcdseq_pkg::CMD_BLINK;
      default:                job_valid_o = 1'b0;
    endcase
  end

endmodule

### design/lcdseq_fifo.sv
// ----------------------------------------------------------------------------
// lcdseq_fifo
// Small job queue between the request decoder and the step generator.
// ----------------------------------------------------------------------------
module lcdseq_fifo #(
  parameter int unsigned Depth = lcdseq_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcdseq_pkg::job_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output lcdseq_pkg::job_t pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  lcdseq_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/lcdseq_back.sv
// ----------------------------------------------------------------------------
// lcdseq_back
// Walks the job at the queue head one step per cycle into an output register, holding while a step waits on the sink.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcdseq_pkg::job_t job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output lcdseq_pkg::step_t step_o,
  output logic             step_valid_o,
  input  logic             step_ready_i
);

  logic [lcdseq_pkg::STEP_W-1:0] idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  lcdseq_pkg::step_t             out_q, cur_step;
  logic                          advance;

  // A byte goes out as four steps: high nibble with enable high then low,
  // then the low nibble the same way.
  always_comb begin
    if (job_i.is_init) begin
      cur_step = lcdseq_pkg::init_step(idx_q);
    end else begin
      cur_step.nibble = idx_q[1] ? job_i.data[3:0] : job_i.data[7:4];
      cur_step.en     = ~idx_q[0];
      cur_step.sel    = job_i.sel;
      cur_step.last   = (idx_q == lcdseq_pkg::BYTE_LAST_STEP);
      if (!idx_q[0]) begin
        cur_step.hold = lcdseq_pkg::HOLD_EN_HIGH;
      end else if (cur_step.last && job_i.long_tail) begin
        cur_step.hold = lcdseq_pkg::HOLD_LONG;
      end else begin
        cur_step.hold = lcdseq_pkg::HOLD_EN_LOW;
      end
    end
  end

  assign advance   = !job_empty_i && (!out_valid_q || step_ready_i);
  assign job_pop_o = advance && cur_step.last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = cur_step.last ? '0 : idx_q + 1'b1;
    end else if (step_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= cur_step;
    end
  end

  assign step_o       = out_q;
  assign step_valid_o = out_valid_q;

endmodule

### design/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Expands LCD requests into pin-state steps for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Each accepted request beat is decoded and queued; the step generator then
// emits one step beat per cycle while the sink is ready. A byte request
// (command, character, clear, cursor set, cursor on, blink) produces four
// steps; init produces 25 steps. The step generator, one step per cycle,
// sets the sustained rate while the sink is ready. Requests are
// taken while the job queue has room, so a new request enters while the
// previous one is still being stepped out. Action code 7 produces no steps.
// The last step of each request's run carries tlast. Read/write is not driven
// here and belongs low on the board.
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned QueueDepth = lcdseq_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] action, [10:3] value, [16:11] column, [17] row, [23:18] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] nibble, [4] enable_level, [5] select_level, [20:6] hold_us,
  // [23:21] zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  lcdseq_pkg::job_t  dec_job, head_job;
  lcdseq_pkg::step_t step;
  logic              dec_valid, q_full, q_empty, q_pop;

  lcdseq_front u_front (
    .req_data_i  (s_axis_tdata_i),
    .job_o       (dec_job),
    .job_valid_o (dec_valid)
  );

  lcdseq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i && dec_valid),
    .push_data_i (dec_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (head_job),
    .empty_o     (q_empty)
  );

  lcdseq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .job_empty_i  (q_empty),
    .job_pop_o    (q_pop),
    .step_o       (step),
    .step_valid_o (m_axis_tvalid_o),
    .step_ready_i (m_axis_tready_i)
  );

  assign s_axis_tready_o = !q_full;
  assign m_axis_tdata_o  = {3'b000, step.hold, step.sel, step.en, step.nibble};
  assign m_axis_tlast_o  = step.last;

endmodule
